>>> hdl/rpid_pkg.sv
// Shared constants and types for the run-length palette image decoder.
package rpid_pkg;

    // Storage sizes
    localparam int RUN_AW = 10;
    localparam logic [31:0] MAX_RUNS = 32'd1024;
    localparam int PAL_AW = 8;
    localparam logic [31:0] PAL_DEPTH = 32'd256;

    // Mode flag bit positions
    localparam int FLAG_PAL = 0;
    localparam int FLAG_GRAY = 1;
    localparam int FLAG_RUN = 2;

    // Request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_DIMS = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // File parse phases
    typedef enum logic [13:0] {
        PH_PREAMBLE = 14'b00000000000001,
        PH_DIMS     = 14'b00000000000010,
        PH_CTSIZE   = 14'b00000000000100,
        PH_FLAGS    = 14'b00000000001000,
        PH_RESERVED = 14'b00000000010000,
        PH_MESSAGE  = 14'b00000000100000,
        PH_PAL_SKIP = 14'b00000001000000,
        PH_PAL_LOAD = 14'b00000010000000,
        PH_RAW      = 14'b00000100000000,
        PH_RUNCOUNT = 14'b00001000000000,
        PH_RUNLEN   = 14'b00010000000000,
        PH_RUNCOLOR = 14'b00100000000000,
        PH_DRAIN    = 14'b01000000000000,
        PH_DONE     = 14'b10000000000000
    } phase_t;

    // Memory access sequencer
    typedef enum logic [5:0] {
        C_IDLE  = 6'b000001,
        C_PIX   = 6'b000010,
        C_COLOR = 6'b000100,
        C_LOADA = 6'b001000,
        C_LOADB = 6'b010000,
        C_TICK  = 6'b100000
    } ctl_t;

endpackage

>>> hdl/rle_palette_image_decoder_unit.sv
// Top level of the run-length palette image decoder.
// A byte request is handled as it is accepted; a request that completes a raw pixel
// or a run colour, and a drain tick, also pass a second state that reads the memories.
// Throughput: one request per cycle while idle and not held by out_ready, none during
// that second state; the start of draining adds LOADA and LOADB to fetch the first run length.
// Reset: asynchronous, clears control state and palette valid bits at once.
module rle_palette_image_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last_pixel,
    output logic        overflow
);

    rpid_pkg::phase_t phase_reg, phase_next;
    rpid_pkg::ctl_t   ctl_reg, ctl_next;
    logic [31:0] fc_reg, fc_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  slot_reg, slot_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] pix_left_reg, pix_left_next;
    logic [31:0] pal_entries_reg, pal_entries_next;
    logic [2:0]  flags_reg, flags_next;
    logic [31:0] run_total_reg, run_total_next;
    logic [rpid_pkg::RUN_AW:0] emit_idx_reg, emit_idx_next;
    logic [31:0] emit_left_reg, emit_left_next;
    logic        ovf_reg, ovf_next;
    logic [(1<<rpid_pkg::PAL_AW)-1:0] pal_valid_reg, pal_valid_next;
    logic        pal_hit_reg, pal_hit_next;
    logic        use_pal_reg, use_pal_next;
    logic [23:0] pend_rgb_reg, pend_rgb_next;
    logic        pend_last_reg, pend_last_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [15:0] ow_reg, ow_next;
    logic [15:0] oh_reg, oh_next;
    logic [23:0] orgb_reg, orgb_next;
    logic        olast_reg, olast_next;
    logic        oovf_reg, oovf_next;

    // Memory ports
    logic                       pal_we;
    logic [rpid_pkg::PAL_AW-1:0] pal_waddr;
    logic [23:0]                pal_wdata;
    logic [23:0]                pal_rdata;
    logic                       len_we;
    logic [rpid_pkg::RUN_AW-1:0] len_waddr;
    logic [31:0]                len_wdata;
    logic                       len_re;
    logic [rpid_pkg::RUN_AW-1:0] len_raddr;
    logic [31:0]                len_rdata;
    logic                       col_we;
    logic [rpid_pkg::RUN_AW-1:0] col_waddr;
    logic [23:0]                col_wdata;
    logic [23:0]                col_rdata;

    logic        accept;
    logic [31:0] acc_shift;
    logic [31:0] fc_inc;
    logic [31:0] area;
    logic        is_pal;
    logic        is_gray;
    logic [23:0] gray_rgb;
    logic [23:0] triple_rgb;
    logic [23:0] done_rgb;
    logic        keep_run;
    logic [31:0] stored;
    logic [31:0] left_dec;
    logic [rpid_pkg::RUN_AW:0] idx_inc;

    assign accept = in_valid && in_ready;
    assign in_ready = (ctl_reg == rpid_pkg::C_IDLE) && (!out_valid_reg || out_ready);

    assign acc_shift = {acc_reg[23:0], data_byte};
    assign fc_inc = fc_reg + 32'd1;
    assign area = acc_shift[31:16] * acc_shift[15:0];
    assign is_pal = flags_reg[rpid_pkg::FLAG_PAL];
    assign is_gray = flags_reg[rpid_pkg::FLAG_GRAY];
    assign gray_rgb = {data_byte, data_byte, data_byte};
    assign triple_rgb = {pc_reg, data_byte};
    assign done_rgb = use_pal_reg ? (pal_hit_reg ? pal_rdata : 24'd0) : pend_rgb_reg;
    assign keep_run = (fc_reg < rpid_pkg::MAX_RUNS) && (len_rdata != 32'd0)
                      && (acc_reg < rpid_pkg::MAX_RUNS);
    assign stored = keep_run ? (acc_reg + 32'd1) : acc_reg;
    assign left_dec = emit_left_reg - 32'd1;
    assign idx_inc = emit_idx_reg + 1'b1;

    // Read ports follow the request
    assign len_re = accept || (ctl_reg == rpid_pkg::C_LOADA);
    assign len_raddr = (ctl_reg == rpid_pkg::C_LOADA) ? '0 :
                       (phase_reg == rpid_pkg::PH_DRAIN) ? idx_inc[rpid_pkg::RUN_AW-1:0] :
                       fc_reg[rpid_pkg::RUN_AW-1:0];

    rpid_ram #(.ADDR_W(rpid_pkg::PAL_AW), .DATA_W(24)) u_pal (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (pal_waddr),
        .wr_data (pal_wdata),
        .rd_en   (accept),
        .rd_addr (data_byte),
        .rd_data (pal_rdata)
    );

    rpid_ram #(.ADDR_W(rpid_pkg::RUN_AW), .DATA_W(32)) u_len (
        .clk     (clk),
        .wr_en   (len_we),
        .wr_addr (len_waddr),
        .wr_data (len_wdata),
        .rd_en   (len_re),
        .rd_addr (len_raddr),
        .rd_data (len_rdata)
    );

    rpid_ram #(.ADDR_W(rpid_pkg::RUN_AW), .DATA_W(24)) u_col (
        .clk     (clk),
        .wr_en   (col_we),
        .wr_addr (col_waddr),
        .wr_data (col_wdata),
        .rd_en   (accept),
        .rd_addr (emit_idx_reg[rpid_pkg::RUN_AW-1:0]),
        .rd_data (col_rdata)
    );

    // Parse the stream and sequence memory accesses
    always_comb
    begin
        phase_next = phase_reg;
        ctl_next = ctl_reg;
        fc_next = fc_reg;
        acc_next = acc_reg;
        slot_next = slot_reg;
        pc_next = pc_reg;
        width_next = width_reg;
        height_next = height_reg;
        pix_left_next = pix_left_reg;
        pal_entries_next = pal_entries_reg;
        flags_next = flags_reg;
        run_total_next = run_total_reg;
        emit_idx_next = emit_idx_reg;
        emit_left_next = emit_left_reg;
        ovf_next = ovf_reg;
        pal_valid_next = pal_valid_reg;
        pal_hit_next = pal_valid_reg[data_byte];
        use_pal_next = use_pal_reg;
        pend_rgb_next = pend_rgb_reg;
        pend_last_next = pend_last_reg;

        out_valid_next = out_valid_reg && !out_ready;
        kind_next = kind_reg;
        ow_next = ow_reg;
        oh_next = oh_reg;
        orgb_next = orgb_reg;
        olast_next = olast_reg;
        oovf_next = oovf_reg;

        pal_we = 1'b0;
        pal_waddr = fc_reg[rpid_pkg::PAL_AW-1:0];
        pal_wdata = triple_rgb;
        len_we = 1'b0;
        len_waddr = fc_reg[rpid_pkg::RUN_AW-1:0];
        len_wdata = acc_shift;
        col_we = 1'b0;
        col_waddr = acc_reg[rpid_pkg::RUN_AW-1:0];
        col_wdata = done_rgb;

        unique case (ctl_reg)
            rpid_pkg::C_IDLE:
            begin
                if (accept && opcode == rpid_pkg::OP_TICK)
                begin
                    if (phase_reg == rpid_pkg::PH_DRAIN)
                    begin
                        ctl_next = rpid_pkg::C_TICK;
                    end
                end
                else if (accept)
                begin
                    unique case (phase_reg) inside
                        rpid_pkg::PH_PREAMBLE:
                        begin
                            fc_next = fc_inc;
                            if (fc_reg == 32'd13)
                            begin
                                phase_next = rpid_pkg::PH_DIMS;
                                fc_next = '0;
                                acc_next = '0;
                                slot_next = '0;
                            end
                        end
                        rpid_pkg::PH_DIMS:
                        begin
                            acc_next = acc_shift;
                            fc_next = fc_inc;
                            if (fc_reg == 32'd3)
                            begin
                                width_next = acc_shift[31:16];
                                height_next = acc_shift[15:0];
                                pix_left_next = area;
                                phase_next = rpid_pkg::PH_CTSIZE;
                                fc_next = '0;
                                acc_next = '0;
                                slot_next = '0;
                                out_valid_next = 1'b1;
                                kind_next = rpid_pkg::KIND_DIMS;
                                ow_next = acc_shift[31:16];
                                oh_next = acc_shift[15:0];
                                orgb_next = '0;
                                olast_next = 1'b0;
                                oovf_next = ovf_reg;
                            end
                        end
                        rpid_pkg::PH_CTSIZE:
                        begin
                            acc_next = acc_shift;
                            fc_next = fc_inc;
                            if (fc_reg == 32'd3)
                            begin
                                pal_entries_next = acc_shift;
                                phase_next = rpid_pkg::PH_FLAGS;
                                fc_next = '0;
                                acc_next = '0;
                                slot_next = '0;
                            end
                        end
                        rpid_pkg::PH_FLAGS:
                        begin
                            flags_next = data_byte[7:5];
                            phase_next = rpid_pkg::PH_RESERVED;
                            fc_next = '0;
                            acc_next = '0;
                            slot_next = '0;
                        end
                        rpid_pkg::PH_RESERVED:
                        begin
                            fc_next = fc_inc;
                            if (fc_reg == 32'd2)
                            begin
                                phase_next = rpid_pkg::PH_MESSAGE;
                                fc_next = '0;
                                acc_next = '0;
                                slot_next = '0;
                            end
                        end
                        rpid_pkg::PH_MESSAGE:
                        begin
                            if (data_byte == 8'd0)
                            begin
                                fc_next = '0;
                                acc_next = '0;
                                slot_next = '0;
                                if (!is_pal)
                                begin
                                    phase_next = rpid_pkg::PH_PAL_SKIP;
                                end
                                else if (pal_entries_reg != 32'd0)
                                begin
                                    phase_next = rpid_pkg::PH_PAL_LOAD;
                                end
                                else if (flags_reg[rpid_pkg::FLAG_RUN])
                                begin
                                    phase_next = rpid_pkg::PH_RUNCOUNT;
                                end
                                else if (pix_left_reg == 32'd0)
                                begin
                                    phase_next = rpid_pkg::PH_DONE;
                                end
                                else
                                begin
                                    phase_next = rpid_pkg::PH_RAW;
                                end
                            end
                        end
                        rpid_pkg::PH_PAL_SKIP, rpid_pkg::PH_PAL_LOAD:
                        begin
                            if (phase_reg == rpid_pkg::PH_PAL_LOAD && slot_reg == 2'd0)
                            begin
                                pc_next = {data_byte, 8'd0};
                                slot_next = 2'd1;
                            end
                            else if (phase_reg == rpid_pkg::PH_PAL_LOAD && slot_reg == 2'd1)
                            begin
                                pc_next = {pc_reg[15:8], data_byte};
                                slot_next = 2'd2;
                            end
                            else
                            begin
                                slot_next = 2'd0;
                                fc_next = fc_inc;
                                if (phase_reg == rpid_pkg::PH_PAL_LOAD)
                                begin
                                    if (fc_reg < rpid_pkg::PAL_DEPTH)
                                    begin
                                        pal_we = 1'b1;
                                        pal_valid_next[fc_reg[rpid_pkg::PAL_AW-1:0]] = 1'b1;
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                end
                                if ((phase_reg == rpid_pkg::PH_PAL_LOAD
                                     && fc_inc == pal_entries_reg)
                                    || (phase_reg == rpid_pkg::PH_PAL_SKIP
                                     && fc_reg == 32'd3))
                                begin
                                    fc_next = '0;
                                    acc_next = '0;
                                    if (flags_reg[rpid_pkg::FLAG_RUN])
                                    begin
                                        phase_next = rpid_pkg::PH_RUNCOUNT;
                                    end
                                    else if (pix_left_reg == 32'd0)
                                    begin
                                        phase_next = rpid_pkg::PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = rpid_pkg::PH_RAW;
                                    end
                                end
                            end
                        end
                        rpid_pkg::PH_RAW, rpid_pkg::PH_RUNCOLOR:
                        begin
                            // Palette wins in run mode, gray wins in raw mode
                            if (is_pal && (phase_reg == rpid_pkg::PH_RUNCOLOR || !is_gray))
                            begin
                                use_pal_next = 1'b1;
                                ctl_next = (phase_reg == rpid_pkg::PH_RAW)
                                           ? rpid_pkg::C_PIX : rpid_pkg::C_COLOR;
                            end
                            else if (is_gray)
                            begin
                                use_pal_next = 1'b0;
                                pend_rgb_next = gray_rgb;
                                ctl_next = (phase_reg == rpid_pkg::PH_RAW)
                                           ? rpid_pkg::C_PIX : rpid_pkg::C_COLOR;
                            end
                            else if (slot_reg == 2'd0)
                            begin
                                pc_next = {data_byte, 8'd0};
                                slot_next = 2'd1;
                            end
                            else if (slot_reg == 2'd1)
                            begin
                                pc_next = {pc_reg[15:8], data_byte};
                                slot_next = 2'd2;
                            end
                            else
                            begin
                                slot_next = 2'd0;
                                use_pal_next = 1'b0;
                                pend_rgb_next = triple_rgb;
                                ctl_next = (phase_reg == rpid_pkg::PH_RAW)
                                           ? rpid_pkg::C_PIX : rpid_pkg::C_COLOR;
                            end
                            // Count the raw pixel now, emit it after the read
                            if (phase_reg == rpid_pkg::PH_RAW && ctl_next == rpid_pkg::C_PIX)
                            begin
                                pix_left_next = pix_left_reg - 32'd1;
                                pend_last_next = (pix_left_reg == 32'd1);
                                if (pix_left_reg == 32'd1)
                                begin
                                    phase_next = rpid_pkg::PH_DONE;
                                    fc_next = '0;
                                    acc_next = '0;
                                    slot_next = '0;
                                end
                            end
                        end
                        rpid_pkg::PH_RUNCOUNT:
                        begin
                            acc_next = acc_shift;
                            fc_next = fc_inc;
                            if (fc_reg == 32'd3)
                            begin
                                run_total_next = acc_shift;
                                phase_next = (acc_shift == 32'd0)
                                             ? rpid_pkg::PH_DONE : rpid_pkg::PH_RUNLEN;
                                fc_next = '0;
                                acc_next = '0;
                                slot_next = '0;
                            end
                        end
                        rpid_pkg::PH_RUNLEN:
                        begin
                            acc_next = acc_shift;
                            if (slot_reg != 2'd3)
                            begin
                                slot_next = slot_reg + 2'd1;
                            end
                            else
                            begin
                                slot_next = 2'd0;
                                if (fc_reg < rpid_pkg::MAX_RUNS)
                                begin
                                    len_we = 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                                acc_next = '0;
                                fc_next = fc_inc;
                                if (fc_inc == run_total_reg)
                                begin
                                    phase_next = rpid_pkg::PH_RUNCOLOR;
                                    fc_next = '0;
                                end
                            end
                        end
                        default:
                        begin
                            // Drop bytes while draining or after the image
                        end
                    endcase
                end
            end
            rpid_pkg::C_PIX:
            begin
                out_valid_next = 1'b1;
                kind_next = rpid_pkg::KIND_PIXEL;
                ow_next = '0;
                oh_next = '0;
                orgb_next = done_rgb;
                olast_next = pend_last_reg;
                oovf_next = ovf_reg;
                ctl_next = rpid_pkg::C_IDLE;
            end
            rpid_pkg::C_COLOR:
            begin
                // Compact nonempty runs toward the front
                len_waddr = acc_reg[rpid_pkg::RUN_AW-1:0];
                len_wdata = len_rdata;
                if (keep_run)
                begin
                    len_we = 1'b1;
                    col_we = 1'b1;
                end
                ctl_next = rpid_pkg::C_IDLE;
                if (fc_inc == run_total_reg)
                begin
                    phase_next = rpid_pkg::PH_DRAIN;
                    fc_next = '0;
                    acc_next = '0;
                    slot_next = '0;
                    run_total_next = stored;
                    if (stored == 32'd0)
                    begin
                        phase_next = rpid_pkg::PH_DONE;
                    end
                    else
                    begin
                        emit_idx_next = '0;
                        ctl_next = rpid_pkg::C_LOADA;
                    end
                end
                else
                begin
                    fc_next = fc_inc;
                    acc_next = stored;
                end
            end
            rpid_pkg::C_LOADA:
            begin
                ctl_next = rpid_pkg::C_LOADB;
            end
            rpid_pkg::C_LOADB:
            begin
                emit_left_next = len_rdata;
                ctl_next = rpid_pkg::C_IDLE;
            end
            rpid_pkg::C_TICK:
            begin
                out_valid_next = 1'b1;
                kind_next = rpid_pkg::KIND_PIXEL;
                ow_next = '0;
                oh_next = '0;
                orgb_next = col_rdata;
                olast_next = 1'b0;
                oovf_next = ovf_reg;
                emit_left_next = left_dec;
                if (left_dec == 32'd0)
                begin
                    emit_idx_next = idx_inc;
                    if ({{(31-rpid_pkg::RUN_AW){1'b0}}, idx_inc} >= run_total_reg)
                    begin
                        olast_next = 1'b1;
                        phase_next = rpid_pkg::PH_DONE;
                    end
                    else
                    begin
                        emit_left_next = len_rdata;
                    end
                end
                ctl_next = rpid_pkg::C_IDLE;
            end
            default:
            begin
                ctl_next = rpid_pkg::C_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rpid_pkg::PH_PREAMBLE;
            ctl_reg <= rpid_pkg::C_IDLE;
            fc_reg <= '0;
            acc_reg <= '0;
            slot_reg <= '0;
            pc_reg <= '0;
            width_reg <= '0;
            height_reg <= '0;
            pix_left_reg <= '0;
            pal_entries_reg <= '0;
            flags_reg <= '0;
            run_total_reg <= '0;
            emit_idx_reg <= '0;
            emit_left_reg <= '0;
            ovf_reg <= 1'b0;
            pal_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            ctl_reg <= ctl_next;
            fc_reg <= fc_next;
            acc_reg <= acc_next;
            slot_reg <= slot_next;
            pc_reg <= pc_next;
            width_reg <= width_next;
            height_reg <= height_next;
            pix_left_reg <= pix_left_next;
            pal_entries_reg <= pal_entries_next;
            flags_reg <= flags_next;
            run_total_reg <= run_total_next;
            emit_idx_reg <= emit_idx_next;
            emit_left_reg <= emit_left_next;
            ovf_reg <= ovf_next;
            pal_valid_reg <= pal_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pal_hit_reg <= pal_hit_next;
        use_pal_reg <= use_pal_next;
        pend_rgb_reg <= pend_rgb_next;
        pend_last_reg <= pend_last_next;
        kind_reg <= kind_next;
        ow_reg <= ow_next;
        oh_reg <= oh_next;
        orgb_reg <= orgb_next;
        olast_reg <= olast_next;
        oovf_reg <= oovf_next;
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign image_width = ow_reg;
    assign image_height = oh_reg;
    assign red = orgb_reg[23:16];
    assign green = orgb_reg[15:8];
    assign blue = orgb_reg[7:0];
    assign last_pixel = olast_reg;
    assign overflow = oovf_reg;

endmodule

>>> hdl/rpid_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module rpid_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> bench/rle_palette_image_decoder_unit_test.sv
// Self-checking bench for the run-length palette image decoder: one random image file per run.
module rle_palette_image_decoder_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
    } request_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        last;
        logic        ovf;
    } pixel_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
    logic        overflow;

    request_t   pending_q[$];
    pixel_res_t expected_q[$];
    int         err_count;
    int         sent_count;
    int         cycle_count;
    logic       hold_off;

    // Decoder shadow state
    rpid_pkg::phase_t ph;
    logic [31:0] fcount;
    logic [31:0] acc;
    logic [15:0] part_rgb;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic [31:0] pix_left;
    logic [31:0] pal_count;
    logic [2:0]  flags;
    logic [23:0] pal_mem[256];
    logic [31:0] runs;
    logic [31:0] len_mem[1024];
    logic [23:0] col_mem[1024];
    logic [31:0] run_idx;
    logic [31:0] run_left;
    logic        ovf_flag;
    logic [1:0]  slot;

    rle_palette_image_decoder_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .image_width(image_width), .image_height(image_height),
        .red(red), .green(green), .blue(blue),
        .last_pixel(last_pixel), .overflow(overflow)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic enter(input rpid_pkg::phase_t p);
        ph = p;
        fcount = '0;
        acc = '0;
        slot = '0;
    endtask

    task automatic emit(input logic k, input logic [23:0] rgb, input logic lst);
        pixel_res_t e;
        e.kind = k;
        e.w = k ? 16'd0 : wid;
        e.h = k ? 16'd0 : hgt;
        e.r = rgb[23:16];
        e.g = rgb[15:8];
        e.b = rgb[7:0];
        e.last = lst;
        e.ovf = ovf_flag;
        expected_q.push_back(e);
    endtask

    task automatic leave_palette();
        if (flags[rpid_pkg::FLAG_RUN])
            enter(rpid_pkg::PH_RUNCOUNT);
        else if (pix_left == 0)
            enter(rpid_pkg::PH_DONE);
        else
            enter(rpid_pkg::PH_RAW);
    endtask

    // Resolve one colour byte; true once a whole colour is ready
    function automatic bit take_colour(input logic [7:0] b, input bit pal_first,
                                       output logic [23:0] rgb);
        rgb = '0;
        if (flags[rpid_pkg::FLAG_PAL] && (pal_first || !flags[rpid_pkg::FLAG_GRAY]))
        begin
            rgb = pal_mem[b];
            return 1'b1;
        end
        if (flags[rpid_pkg::FLAG_GRAY])
        begin
            rgb = {b, b, b};
            return 1'b1;
        end
        if (slot == 2'd0)
        begin
            part_rgb = {b, 8'd0};
            slot = 2'd1;
            return 1'b0;
        end
        if (slot == 2'd1)
        begin
            part_rgb[7:0] = b;
            slot = 2'd2;
            return 1'b0;
        end
        slot = 2'd0;
        rgb = {part_rgb, b};
        return 1'b1;
    endfunction

    // Advance the shadow decoder by one accepted request
    task automatic decode_request(input logic op, input logic [7:0] b);
        logic [23:0] rgb;
        logic [31:0] i;
        logic        lst;
        logic [31:0] stored;
        if (op == rpid_pkg::OP_TICK)
        begin
            if (ph != rpid_pkg::PH_DRAIN)
                return;
            i = run_idx;
            if (i >= rpid_pkg::MAX_RUNS || i >= runs)
            begin
                ph = rpid_pkg::PH_DONE;
                return;
            end
            rgb = col_mem[i];
            lst = 1'b0;
            run_left = run_left - 1;
            if (run_left == 0)
            begin
                i = i + 1;
                run_idx = i;
                if (i >= runs || i >= rpid_pkg::MAX_RUNS)
                begin
                    lst = 1'b1;
                    ph = rpid_pkg::PH_DONE;
                end
                else
                    run_left = len_mem[i];
            end
            emit(rpid_pkg::KIND_PIXEL, rgb, lst);
            return;
        end
        case (ph)
            rpid_pkg::PH_PREAMBLE:
            begin
                fcount = fcount + 1;
                if (fcount == 14)
                    enter(rpid_pkg::PH_DIMS);
            end
            rpid_pkg::PH_DIMS:
            begin
                acc = {acc[23:0], b};
                fcount = fcount + 1;
                if (fcount == 4)
                begin
                    wid = acc[31:16];
                    hgt = acc[15:0];
                    pix_left = 32'(wid) * 32'(hgt);
                    enter(rpid_pkg::PH_CTSIZE);
                    emit(rpid_pkg::KIND_DIMS, 24'd0, 1'b0);
                end
            end
            rpid_pkg::PH_CTSIZE:
            begin
                acc = {acc[23:0], b};
                fcount = fcount + 1;
                if (fcount == 4)
                begin
                    pal_count = acc;
                    enter(rpid_pkg::PH_FLAGS);
                end
            end
            rpid_pkg::PH_FLAGS:
            begin
                flags = b[7:5];
                enter(rpid_pkg::PH_RESERVED);
            end
            rpid_pkg::PH_RESERVED:
            begin
                fcount = fcount + 1;
                if (fcount == 3)
                    enter(rpid_pkg::PH_MESSAGE);
            end
            rpid_pkg::PH_MESSAGE:
            begin
                if (b == 8'd0)
                begin
                    if (!flags[rpid_pkg::FLAG_PAL])
                        enter(rpid_pkg::PH_PAL_SKIP);
                    else if (pal_count == 0)
                        leave_palette();
                    else
                        enter(rpid_pkg::PH_PAL_LOAD);
                end
            end
            rpid_pkg::PH_PAL_SKIP:
            begin
                fcount = fcount + 1;
                if (fcount == 4)
                    leave_palette();
            end
            rpid_pkg::PH_PAL_LOAD:
            begin
                if (slot == 2'd0)
                begin
                    part_rgb = {b, 8'd0};
                    slot = 2'd1;
                end
                else if (slot == 2'd1)
                begin
                    part_rgb[7:0] = b;
                    slot = 2'd2;
                end
                else
                begin
                    slot = 2'd0;
                    if (fcount < rpid_pkg::PAL_DEPTH)
                        pal_mem[fcount[7:0]] = {part_rgb, b};
                    else
                        ovf_flag = 1'b1;
                    fcount = fcount + 1;
                    if (fcount == pal_count)
                        leave_palette();
                end
            end
            rpid_pkg::PH_RAW:
            begin
                if (take_colour(b, 1'b0, rgb))
                begin
                    pix_left = pix_left - 1;
                    if (pix_left == 0)
                    begin
                        enter(rpid_pkg::PH_DONE);
                        emit(rpid_pkg::KIND_PIXEL, rgb, 1'b1);
                    end
                    else
                        emit(rpid_pkg::KIND_PIXEL, rgb, 1'b0);
                end
            end
            rpid_pkg::PH_RUNCOUNT:
            begin
                acc = {acc[23:0], b};
                fcount = fcount + 1;
                if (fcount == 4)
                begin
                    runs = acc;
                    if (runs == 0)
                        enter(rpid_pkg::PH_DONE);
                    else
                        enter(rpid_pkg::PH_RUNLEN);
                end
            end
            rpid_pkg::PH_RUNLEN:
            begin
                acc = {acc[23:0], b};
                if (slot < 2'd3)
                    slot = slot + 1;
                else
                begin
                    slot = 2'd0;
                    if (fcount < rpid_pkg::MAX_RUNS)
                        len_mem[fcount[9:0]] = acc;
                    else
                        ovf_flag = 1'b1;
                    acc = '0;
                    fcount = fcount + 1;
                    if (fcount == runs)
                        enter(rpid_pkg::PH_RUNCOLOR);
                end
            end
            rpid_pkg::PH_RUNCOLOR:
            begin
                if (take_colour(b, 1'b1, rgb))
                begin
                    // acc counts the nonempty runs kept so far
                    if (fcount < rpid_pkg::MAX_RUNS && len_mem[fcount[9:0]] != 0
                        && acc < rpid_pkg::MAX_RUNS)
                    begin
                        len_mem[acc[9:0]] = len_mem[fcount[9:0]];
                        col_mem[acc[9:0]] = rgb;
                        acc = acc + 1;
                    end
                    fcount = fcount + 1;
                    if (fcount == runs)
                    begin
                        stored = acc;
                        enter(rpid_pkg::PH_DRAIN);
                        runs = stored;
                        if (stored == 0)
                            ph = rpid_pkg::PH_DONE;
                        else
                        begin
                            run_idx = '0;
                            run_left = len_mem[0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR: %s got 0x%0h want 0x%0h (cycle %0d)", what, got, want, cycle_count);
        err_count++;
    endtask

    // Idle profile rotates every 120 requests
    function automatic int send_idle_pct();
        case ((sent_count / 120) % 4)
            1: return 56;
            3: return 14;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case ((sent_count / 120) % 4)
            2: return 56;
            3: return 14;
            default: return 0;
        endcase
    endfunction

    // Driver: offer queued requests, hold until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= rpid_pkg::OP_BYTE;
            data_byte <= 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_request(opcode, data_byte);
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    request_t req;
                    req = pending_q.pop_front();
                    in_valid <= 1'b1;
                    opcode <= req.op;
                    data_byte <= req.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("rle_palette_image_decoder_unit: mismatch");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result kind", 32'(kind), 32'd0);
                else
                begin
                    pixel_res_t e;
                    e = expected_q.pop_front();
                    if (kind !== e.kind) report_mismatch("kind", 32'(kind), 32'(e.kind));
                    if (image_width !== e.w)
                        report_mismatch("image_width", 32'(image_width), 32'(e.w));
                    if (image_height !== e.h)
                        report_mismatch("image_height", 32'(image_height), 32'(e.h));
                    if (red !== e.r) report_mismatch("red", 32'(red), 32'(e.r));
                    if (green !== e.g) report_mismatch("green", 32'(green), 32'(e.g));
                    if (blue !== e.b) report_mismatch("blue", 32'(blue), 32'(e.b));
                    if (last_pixel !== e.last)
                        report_mismatch("last_pixel", 32'(last_pixel), 32'(e.last));
                    if (overflow !== e.ovf)
                        report_mismatch("overflow", 32'(overflow), 32'(e.ovf));
                end
            end
            out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct());
        end
    end

    // Long receiver hold-off once pixels flow, so the block backs up and stalls its input
    initial
    begin
        int n;
        hold_off = 1'b0;
        wait (ph == rpid_pkg::PH_RAW || ph == rpid_pkg::PH_DRAIN);
        @(posedge clk);
        hold_off <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic push_byte(input logic [7:0] b);
        request_t req;
        // sprinkle drain ticks as noise outside draining
        if ($urandom_range(0, 19) == 0)
        begin
            req.op = rpid_pkg::OP_TICK;
            req.data = 8'($urandom);
            pending_q.push_back(req);
        end
        req.op = rpid_pkg::OP_BYTE;
        req.data = b;
        pending_q.push_back(req);
    endtask

    task automatic push_word(input logic [31:0] v);
        push_byte(v[31:24]);
        push_byte(v[23:16]);
        push_byte(v[15:8]);
        push_byte(v[7:0]);
    endtask

    task automatic push_tick();
        request_t req;
        req.op = rpid_pkg::OP_TICK;
        req.data = 8'($urandom);
        pending_q.push_back(req);
    endtask

    // Build one image file and run it through the block
    initial
    begin
        int mode;
        int w;
        int h;
        int npal;
        int nruns;
        int total_len;
        int k;
        int pal_bytes;
        int budget;
        logic [2:0] fl;
        logic [31:0] rl;

        err_count = 0;
        sent_count = 0;
        ph = rpid_pkg::PH_PREAMBLE;
        fcount = '0;
        acc = '0;
        slot = '0;
        part_rgb = '0;
        wid = '0;
        hgt = '0;
        pix_left = '0;
        pal_count = '0;
        flags = '0;
        runs = '0;
        run_idx = '0;
        run_left = '0;
        ovf_flag = 1'b0;
        for (k = 0; k < 256; k++)
            pal_mem[k] = '0;
        for (k = 0; k < 1024; k++)
        begin
            len_mem[k] = '0;
            col_mem[k] = '0;
        end

        // Ticks before any byte, and a preamble with extreme byte values
        push_tick();
        push_tick();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hAA);
        push_byte(8'h55);
        for (k = 4; k < 14; k++)
            push_byte(8'($urandom));

        // raw gray, raw palette, raw rgb, run palette, run gray, run rgb
        mode = $urandom_range(0, 5);
        case (mode)
            0: fl = $urandom_range(0, 1) ? 3'b010 : 3'b011;
            1: fl = 3'b001;
            2: fl = 3'b000;
            3: fl = $urandom_range(0, 1) ? 3'b101 : 3'b111;
            4: fl = 3'b110;
            default: fl = 3'b100;
        endcase

        // palette size: sometimes beyond the palette store
        npal = ($urandom_range(0, 2) == 0) ? $urandom_range(257, 270) : $urandom_range(0, 40);
        if (!fl[rpid_pkg::FLAG_PAL])
            npal = $urandom_range(0, 300);

        // size the image so the whole file is about 900 requests
        pal_bytes = fl[rpid_pkg::FLAG_PAL] ? 3 * npal : 4;
        budget = 860 - pal_bytes;
        w = $urandom_range(1, 40);
        h = (budget / ((mode == 2) ? 3 : 1)) / w;
        if (h < 1)
            h = 1;
        if (mode >= 3)
        begin
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
        end
        push_byte(8'(w >> 8));
        push_byte(8'(w));
        push_byte(8'(h >> 8));
        push_byte(8'(h));

        push_word(32'(npal));
        push_byte({fl, 5'($urandom)});
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        for (k = $urandom_range(0, 5); k > 0; k--)
            push_byte(8'($urandom_range(1, 255)));
        push_byte(8'h00);
        if (fl[rpid_pkg::FLAG_PAL])
        begin
            for (k = 0; k < 3 * npal; k++)
                push_byte(8'($urandom));
        end
        else
            push_word($urandom);

        if (mode < 3)
        begin
            // raw pixels, exactly as many as the header asks
            for (k = 0; k < w * h * ((mode == 2) ? 3 : 1); k++)
                push_byte(8'($urandom));
        end
        else
        begin
            nruns = budget / ((mode == 5) ? 11 : 9);
            if (nruns < 1)
                nruns = 1;
            push_word(32'(nruns));
            total_len = 0;
            for (k = 0; k < nruns; k++)
            begin
                case ($urandom_range(0, 9))
                    0: rl = 32'd0;
                    1: rl = 32'd1;
                    default: rl = 32'($urandom_range(1, 8));
                endcase
                total_len += int'(rl);
                push_word(rl);
            end
            for (k = 0; k < nruns * ((mode == 5) ? 3 : 1); k++)
                push_byte(8'($urandom));
            // drain, with stray bytes mixed in and ticks past the end
            for (k = 0; k < total_len + 4; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_q.push_back('{rpid_pkg::OP_BYTE, 8'($urandom)});
                push_tick();
            end
        end
        // trailing requests after the image are ignored
        push_tick();
        push_byte(8'($urandom));

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
        repeat (20) @(posedge clk);
        if (err_count == 0 && expected_q.size() == 0)
            $display("rle_palette_image_decoder_unit: match");
        else
            $display("rle_palette_image_decoder_unit: mismatch");
        $finish;
    end

endmodule
